// ----- sv/slrt_pkg.sv -----
// slrt_pkg: shared types and constants of the leak sensor time base
`default_nettype none
package slrt_pkg;

	// command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_BYTE    = 3'd1;
	localparam logic [2:0] CMD_MODE    = 3'd2;
	localparam logic [2:0] CMD_KICK    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;
	localparam logic [2:0] CMD_RELEASE = 3'd5;

	// operating modes
	localparam logic [2:0] MODE_NORM         = 3'd0;
	localparam logic [2:0] MODE_NOT_STATIC   = 3'd1;
	localparam logic [2:0] MODE_SETTING      = 3'd2;
	localparam logic [2:0] MODE_ERROR        = 3'd3;
	localparam logic [2:0] MODE_SENSOR_ERROR = 3'd4;
	localparam logic [2:0] MODE_LEAK         = 3'd5;
	localparam logic [2:0] MODE_BEFORE_LEAK  = 3'd6;

	// configuration register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_CAPTURE_TICK   = 1'b1;

	// flag bit positions
	localparam int FLAG_TEN_SEC   = 0;
	localparam int FLAG_TWO_SEC   = 1;
	localparam int FLAG_THREE_MIN = 2;

	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
	localparam logic [2:0] WDOG_LIMIT         = 3'd3;
	localparam logic [7:0] LEAK_MINUTES_LEAK  = 8'd185;
	localparam logic [7:0] LEAK_MINUTES_MAX   = 8'd255;
	localparam logic [7:0] RX_DIGIT_OFFSET    = 8'h30;
	localparam logic [7:0] ADDR_BROADCAST     = 8'hFF;
	localparam logic [7:0] ADDR_RESET         = 8'hFF;
	localparam logic [6:0] CAPTURE_TICK_RESET = 7'd50;

	// one word on its way from the input register
	typedef struct packed {
		logic        en;
		logic [2:0]  command;
		logic [7:0]  data;
		logic [15:0] freq_count;
	} step_t;

	// led and relay levels
	typedef struct packed {
		logic rel_leak;
		logic rel_norm;
		logic led_leak;
		logic led_normal;
	} drive_t;

	// time base view of one result word
	typedef struct packed {
		drive_t      drive;
		logic [2:0]  mode;
		logic [2:0]  flags;
		logic [7:0]  leak_minutes;
		logic [15:0] captured;
		logic        restart;
	} tb_result_t;

	// receiver view of one result word
	typedef struct packed {
		logic       written;
		logic [7:0] digit;
		logic [2:0] index;
	} rx_result_t;

endpackage
`default_nettype wire

// ----- sv/slrt_if.sv -----
// slrt_if: valid/ready channel interfaces for input and result words
`default_nettype none
interface slrt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  data;
	logic [15:0] freq_count;

	modport source (output valid, command, data, freq_count, input ready);
	modport sink (input valid, command, data, freq_count, output ready);
endinterface

interface slrt_out_if;
	logic        valid;
	logic        ready;
	logic        led_normal;
	logic        led_leak;
	logic        relay_norm;
	logic        relay_leak;
	logic [2:0]  mode_now;
	logic [2:0]  timer_flags;
	logic [7:0]  leak_minutes;
	logic [15:0] captured_count;
	logic        restart_freq_counter;
	logic        rx_written;
	logic [7:0]  rx_digit;
	logic [2:0]  rx_index;

	modport source (output valid, led_normal, led_leak, relay_norm, relay_leak, mode_now,
		timer_flags, leak_minutes, captured_count, restart_freq_counter, rx_written,
		rx_digit, rx_index, input ready);
	modport sink (input valid, led_normal, led_leak, relay_norm, relay_leak, mode_now,
		timer_flags, leak_minutes, captured_count, restart_freq_counter, rx_written,
		rx_digit, rx_index, output ready);
endinterface
`default_nettype wire

// ----- sv/slrt_timebase.sv -----
// slrt_timebase: tick, second and minute counters, flags, watchdog, leak minutes, drives
`default_nettype none
module slrt_timebase
	import slrt_pkg::*;
#(
	parameter int TICKS_PER_SECOND = 100
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire step_t      step,
	input  wire logic [6:0] capture_tick,
	output tb_result_t      nxt
);

	localparam int TW = $clog2(TICKS_PER_SECOND + 1);
	localparam int CW = (TW > 7) ? TW : 7;

	logic [TW-1:0] tick_q, tick_d, tick_inc;
	logic [5:0]    second_q, second_d, second_inc;
	logic [15:0]   minute_q, minute_d;
	logic [1:0]    min_mod3_q, min_mod3_d;
	logic [2:0]    wdog_q, wdog_d, wdog_inc;
	logic [7:0]    leak_q, leak_d;
	logic [2:0]    mode_q, mode_d;
	logic [2:0]    flag_q, flag_d;
	logic [15:0]   capture_q, capture_d;
	drive_t        drive_q, drive_d;
	logic          restart;
	logic          one, three;

	// next state for the word in the input register
	always_comb begin
		tick_d     = tick_q;
		second_d   = second_q;
		minute_d   = minute_q;
		min_mod3_d = min_mod3_q;
		wdog_d     = wdog_q;
		leak_d     = leak_q;
		mode_d     = mode_q;
		flag_d     = flag_q;
		capture_d  = capture_q;
		drive_d    = drive_q;
		restart    = 1'b0;
		tick_inc   = tick_q + TW'(1);
		second_inc = second_q + 6'd1;
		wdog_inc   = wdog_q + 3'd1;
		one        = 1'b0;
		three      = 1'b0;
		unique case (step.command)
			CMD_TICK: begin
				tick_d = tick_inc;
				if (CW'(tick_inc) == CW'(capture_tick)) begin
					capture_d = step.freq_count;
				end
				if (tick_inc == TW'(TICKS_PER_SECOND)) begin
					second_d = second_inc;
					// minute boundary
					if (second_inc == SECONDS_PER_MINUTE) begin
						if (min_mod3_q == 2'd0) begin
							flag_d[FLAG_THREE_MIN] = 1'b1;
						end
						wdog_d = wdog_inc;
						if (wdog_inc > WDOG_LIMIT) begin
							mode_d = MODE_SENSOR_ERROR;
							wdog_d = WDOG_LIMIT;
						end
						if (mode_d == MODE_BEFORE_LEAK) begin
							if (leak_q != LEAK_MINUTES_MAX) begin
								leak_d = leak_q + 8'd1;
							end
						end else if (mode_d == MODE_LEAK) begin
							leak_d = LEAK_MINUTES_LEAK;
						end else begin
							leak_d = 8'd0;
						end
						minute_d = minute_q + 16'd1;
						// minute count wraps at 2^16, which is not a multiple of 3
						if (minute_q == 16'hFFFF || min_mod3_q == 2'd2) begin
							min_mod3_d = 2'd0;
						end else begin
							min_mod3_d = min_mod3_q + 2'd1;
						end
						second_d = 6'd0;
					end
					if (!second_d[0]) begin
						flag_d[FLAG_TWO_SEC] = 1'b1;
					end
					if (second_d == 6'd0 || second_d == 6'd10 || second_d == 6'd20 ||
						second_d == 6'd30 || second_d == 6'd40 || second_d == 6'd50) begin
						flag_d[FLAG_TEN_SEC] = 1'b1;
					end
					tick_d  = '0;
					restart = 1'b1;
				end
				// blink windows within the second
				one   = tick_d < TW'(5);
				three = one || (tick_d > TW'(10) && tick_d < TW'(15)) ||
					(tick_d > TW'(20) && tick_d < TW'(25));
				unique case (mode_d)
					MODE_NORM: begin
						drive_d = '{rel_leak: 1'b0, rel_norm: 1'b1, led_leak: 1'b0,
							led_normal: one};
					end
					MODE_NOT_STATIC: begin
						drive_d.led_normal = one;
						drive_d.led_leak   = one;
					end
					MODE_SETTING: begin
						drive_d = '{rel_leak: 1'b0, rel_norm: 1'b0, led_leak: 1'b0,
							led_normal: three};
					end
					MODE_ERROR: begin
						drive_d = '{rel_leak: 1'b0, rel_norm: 1'b0, led_leak: three,
							led_normal: 1'b0};
					end
					MODE_SENSOR_ERROR: begin
						drive_d = '{rel_leak: 1'b0, rel_norm: 1'b0, led_leak: three,
							led_normal: !three};
					end
					MODE_LEAK: begin
						drive_d = '{rel_leak: 1'b1, rel_norm: 1'b0, led_leak: one,
							led_normal: 1'b0};
					end
					MODE_BEFORE_LEAK: begin
						drive_d = '{rel_leak: 1'b0, rel_norm: 1'b1, led_leak: one,
							led_normal: 1'b0};
					end
					default: begin
						drive_d = drive_q;
					end
				endcase
			end
			CMD_MODE: begin
				mode_d = step.data[2:0];
			end
			CMD_KICK: begin
				wdog_d = 3'd0;
			end
			CMD_CLEAR: begin
				flag_d = flag_q & ~step.data[7:5];
			end
			default: begin
				tick_d = tick_q;
			end
		endcase
	end

	// state update when the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			second_q   <= '0;
			minute_q   <= '0;
			min_mod3_q <= '0;
			wdog_q     <= '0;
			leak_q     <= '0;
			mode_q     <= MODE_NORM;
			flag_q     <= '0;
			capture_q  <= '0;
			drive_q    <= '0;
		end else if (step.en) begin
			tick_q     <= tick_d;
			second_q   <= second_d;
			minute_q   <= minute_d;
			min_mod3_q <= min_mod3_d;
			wdog_q     <= wdog_d;
			leak_q     <= leak_d;
			mode_q     <= mode_d;
			flag_q     <= flag_d;
			capture_q  <= capture_d;
			drive_q    <= drive_d;
		end
	end

	assign nxt = '{drive: drive_d, mode: mode_d, flags: flag_d, leak_minutes: leak_d,
		captured: capture_d, restart: restart};

endmodule
`default_nettype wire

// ----- sv/slrt_rx.sv -----
// slrt_rx: address-matched frame receiver that turns bytes into digits
`default_nettype none
module slrt_rx
	import slrt_pkg::*;
#(
	parameter int FRAME_DIGITS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire step_t      step,
	input  wire logic [7:0] device_address,
	output rx_result_t      nxt
);

	typedef enum logic [1:0] {
		RX_IDLE     = 2'd0,
		RX_COLLECT  = 2'd1,
		RX_COMPLETE = 2'd2
	} rx_state_t;

	rx_state_t  state_q, state_d;
	logic [3:0] pos_q, pos_d, pos_eff;
	logic       open_frame;

	// frame tracking for one word
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		nxt        = '0;
		open_frame = (step.data == device_address || device_address == ADDR_BROADCAST) &&
			state_q != RX_COLLECT;
		pos_eff    = open_frame ? 4'd0 : pos_q;
		unique case (step.command)
			CMD_BYTE: begin
				if (open_frame || state_q == RX_COLLECT) begin
					nxt.written = 1'b1;
					nxt.digit   = step.data - RX_DIGIT_OFFSET;
					nxt.index   = pos_eff[2:0];
					pos_d       = pos_eff + 4'd1;
					if (({1'b0, pos_eff} + 5'd1) == 5'(FRAME_DIGITS)) begin
						state_d = RX_COMPLETE;
					end else begin
						state_d = RX_COLLECT;
					end
				end
			end
			CMD_RELEASE: begin
				state_d = RX_IDLE;
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	// receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RX_IDLE;
			pos_q   <= '0;
		end else if (step.en) begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/status_led_relay_timebase_unit.sv -----
// status_led_relay_timebase_unit: top level of the leak sensor time base
// path: a word moves from the input register to the result register, which drives the port
// throughput: one word per cycle with result.ready high; input refills while result drains
// the result register stalls only on result.ready, the input register only on a held result
// reset (arst_n low): counters, flags, mode, drives and receiver cleared, registers to defaults
// device_address resets to broadcast, capture_tick to 50
`default_nettype none
module status_led_relay_timebase_unit
	import slrt_pkg::*;
#(
	parameter int TICKS_PER_SECOND = 100,
	parameter int FRAME_DIGITS     = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	slrt_in_if.sink         item,
	slrt_out_if.source      result,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [7:0]  data_s1;
	logic [15:0] freq_s1;
	logic        valid_s2;
	tb_result_t  tb_s2;
	rx_result_t  rx_s2;
	logic [7:0]  device_address_q;
	logic [6:0]  capture_tick_q;
	logic        advance;
	step_t       step;
	tb_result_t  tb_nxt;
	rx_result_t  rx_nxt;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign step       = '{en: advance, command: command_s1, data: data_s1, freq_count: freq_s1};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= ADDR_RESET;
			capture_tick_q   <= CAPTURE_TICK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				REG_CAPTURE_TICK:   capture_tick_q   <= cfg_data[6:0];
				default:            device_address_q <= device_address_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			command_s1 <= item.command;
			data_s1    <= item.data;
			freq_s1    <= item.freq_count;
		end
	end

	slrt_timebase #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_timebase (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.capture_tick (capture_tick_q),
		.nxt          (tb_nxt)
	);

	slrt_rx #(
		.FRAME_DIGITS(FRAME_DIGITS)
	) u_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.device_address (device_address_q),
		.nxt            (rx_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tb_s2 <= tb_nxt;
			rx_s2 <= rx_nxt;
		end
	end

	// result word
	assign result.valid                = valid_s2;
	assign result.led_normal           = tb_s2.drive.led_normal;
	assign result.led_leak             = tb_s2.drive.led_leak;
	assign result.relay_norm           = tb_s2.drive.rel_norm;
	assign result.relay_leak           = tb_s2.drive.rel_leak;
	assign result.mode_now             = tb_s2.mode;
	assign result.timer_flags          = tb_s2.flags;
	assign result.leak_minutes         = tb_s2.leak_minutes;
	assign result.captured_count       = tb_s2.captured;
	assign result.restart_freq_counter = tb_s2.restart;
	assign result.rx_written           = rx_s2.written;
	assign result.rx_digit             = rx_s2.digit;
	assign result.rx_index             = rx_s2.index;

endmodule
`default_nettype wire
